/* hw/rtl/assert_macros.svh */
// Assertion macros shared by the RTL files of the interval partitioner.
// Every macro samples on the rising edge of clk and is disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define GIP_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// When the condition holds, the consequence must hold in the same cycle.
`define GIP_ASSERT_IMPLY(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// When the condition holds, the consequence must hold in the next cycle.
`define GIP_ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/gip_pkg.sv */
// Package of the interval partitioner: widths of the result fields.
// It has no dependencies. The output interface and the top level use it.
`default_nettype none

package gip_pkg;

  localparam int GROUP_W  = 6;
  localparam int NUMBER_W = 7;

endpackage

`default_nettype wire

/* hw/rtl/gip_in_if.sv */
// Request channel that carries one interval into the partitioner.
// It depends on nothing but its time width parameter.
`default_nettype none

interface gip_in_if #(
  parameter int TW = 16
);
  logic          valid;
  logic          ready;
  logic [TW-1:0] start_time;
  logic [TW-1:0] end_time;
  logic          last_interval;

  modport source (output valid, start_time, end_time, last_interval, input ready);
  modport sink   (input valid, start_time, end_time, last_interval, output ready);
endinterface

`default_nettype wire

/* hw/rtl/gip_out_if.sv */
// Request channel that carries one group assignment out of the partitioner.
// It takes its field widths from gip_pkg.
`default_nettype none

interface gip_out_if;
  logic                         valid;
  logic                         ready;
  logic [gip_pkg::GROUP_W-1:0]  group_index;
  logic [gip_pkg::NUMBER_W-1:0] interval_number;
  logic                         group_done;
  logic                         all_done;

  modport source (output valid, group_index, interval_number, group_done, all_done,
                  input ready);
  modport sink   (input valid, group_index, interval_number, group_done, all_done,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/gip_ram.sv */
// Simple dual-port synchronous RAM with a registered read port.
// It has no dependencies.
`default_nettype none

module gip_ram #(
  parameter int AW = 6,
  parameter int DW = 8
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

/* hw/rtl/greedy_interval_partition.sv */
// Greedy interval partitioner. Loading accepts one interval request per cycle.
// After the final interval, ranking reads each interval and compares it with every
// stored interval to place it in sorted order; then every greedy pass scans the stored
// intervals in that order and ends with a closing step that sends the group's last result.
// Reset is synchronous and active high; it clears the controller and the output
// register, and the RAM contents stay undefined until written.
`default_nettype none

module greedy_interval_partition #(
  parameter int MAX_INTERVALS = 64,
  parameter int TIME_WIDTH    = 16
) (
  input wire logic clk,
  input wire logic rst,
  gip_in_if.sink   intervals,
  gip_out_if.source results
);

  `include "assert_macros.svh"

  localparam int AW = $clog2(MAX_INTERVALS);
  localparam int CW = $clog2(MAX_INTERVALS + 1);
  localparam int TW = TIME_WIDTH;
  localparam int EW = 2 * TW + 1;   // taken flag, end, start

  localparam int GW = gip_pkg::GROUP_W;
  localparam int NW = gip_pkg::NUMBER_W;

  // Controller phases: load, rank (every interval counts its predecessors in
  // the sort order and writes itself to that slot), and greedy passes.
  typedef enum logic [2:0] {
    LOAD,
    RK_A,
    RK_L,
    RK_C,
    PS_O,
    PS_OL,
    PS_D,
    PS_E
  } state_t;

  state_t state;

  logic [CW-1:0] count;      // intervals loaded so far
  logic [CW-1:0] n;          // size of the set being processed
  logic [AW-1:0] i;          // interval being ranked
  logic [AW-1:0] j;          // interval compared against
  logic [AW-1:0] rank;       // predecessors of interval i found so far
  logic [TW-1:0] a_start;
  logic [TW-1:0] a_end;
  logic [AW-1:0] k;          // scan position in sorted order
  logic [AW-1:0] idx;        // interval at the scan position
  logic          first;      // no interval taken yet in this pass
  logic [TW-1:0] last_end;
  logic [CW-1:0] done;       // intervals taken in the whole run
  logic [GW-1:0] group;

  // The newest taken interval waits here until we know if it closes its group.
  logic          pend_valid;
  logic [NW-1:0] pend_number;
  logic [GW-1:0] pend_group;

  logic          ovalid;
  logic [GW-1:0] o_group;
  logic [NW-1:0] o_number;
  logic          o_gdone;
  logic          o_adone;

  // Interval RAM
  logic          iv_we;
  logic [AW-1:0] iv_waddr;
  logic [EW-1:0] iv_wdata;
  logic [AW-1:0] iv_raddr;
  logic [EW-1:0] iv_rdata;

  // Sorted-order RAM
  logic          od_we;
  logic [AW-1:0] od_waddr;
  logic [AW-1:0] od_raddr;
  logic [AW-1:0] od_rdata;

  gip_ram #(.AW(AW), .DW(EW)) u_iv_ram (
    .clk   (clk),
    .we    (iv_we),
    .waddr (iv_waddr),
    .wdata (iv_wdata),
    .raddr (iv_raddr),
    .rdata (iv_rdata)
  );

  gip_ram #(.AW(AW), .DW(AW)) u_order_ram (
    .clk   (clk),
    .we    (od_we),
    .waddr (od_waddr),
    .wdata (i),
    .raddr (od_raddr),
    .rdata (od_rdata)
  );

  logic          rd_taken;
  logic [TW-1:0] rd_end;
  logic [TW-1:0] rd_start;
  assign rd_taken = iv_rdata[EW-1];
  assign rd_end   = iv_rdata[2*TW-1:TW];
  assign rd_start = iv_rdata[TW-1:0];

  logic in_fire;
  logic in_final;
  assign intervals.ready = (state == LOAD);
  assign in_fire  = intervals.valid && intervals.ready;
  assign in_final = intervals.last_interval || (count == CW'(MAX_INTERVALS - 1));

  // Interval j precedes interval i: earlier end, then later start, then lower number.
  logic before_hit;
  assign before_hit = (rd_end < a_end) ||
                      ((rd_end == a_end) && ((rd_start > a_start) ||
                                             ((rd_start == a_start) && (j < i))));

  logic j_last;
  logic i_last;
  logic k_last;
  assign j_last = (CW'(j) == n - CW'(1));
  assign i_last = (CW'(i) == n - CW'(1));
  assign k_last = (CW'(k) == n - CW'(1));

  // A greedy pass takes an untaken interval that starts after the last end.
  logic out_free;
  logic take_hit;
  logic can_push;
  assign out_free = !ovalid || results.ready;
  assign take_hit = !rd_taken && (first || (rd_start > last_end));
  assign can_push = !pend_valid || out_free;

  always_comb begin
    iv_we    = 1'b0;
    iv_waddr = count[AW-1:0];
    iv_wdata = {1'b0, intervals.end_time, intervals.start_time};
    iv_raddr = '0;
    od_we    = 1'b0;
    od_waddr = AW'(rank + AW'(before_hit));
    od_raddr = k;
    case (state)
      LOAD: begin
        iv_we = in_fire;
      end
      RK_A: begin
        iv_raddr = i;
      end
      RK_L: begin
        iv_raddr = '0;
      end
      RK_C: begin
        iv_raddr = AW'(j + AW'(1));
        od_we    = j_last;
      end
      PS_OL: begin
        iv_raddr = od_rdata;
      end
      PS_D: begin
        iv_raddr = idx;
        iv_waddr = idx;
        iv_wdata = {1'b1, rd_end, rd_start};
        iv_we    = take_hit && can_push;
      end
      default: begin
        iv_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= LOAD;
      count      <= '0;
      pend_valid <= 1'b0;
      ovalid     <= 1'b0;
    end else begin
      if (results.ready) begin
        ovalid <= 1'b0;
      end
      case (state)
        LOAD: begin
          if (in_fire) begin
            count <= count + CW'(1);
            if (in_final) begin
              n     <= count + CW'(1);
              i     <= '0;
              state <= RK_A;
            end
          end
        end
        RK_A: begin
          state <= RK_L;
        end
        RK_L: begin
          a_start <= rd_start;
          a_end   <= rd_end;
          j       <= '0;
          rank    <= '0;
          state   <= RK_C;
        end
        RK_C: begin
          rank <= AW'(rank + AW'(before_hit));
          j    <= AW'(j + AW'(1));
          if (j_last) begin
            i <= AW'(i + AW'(1));
            if (i_last) begin
              k        <= '0;
              first    <= 1'b1;
              done     <= '0;
              group    <= '0;
              state    <= PS_O;
            end else begin
              state <= RK_A;
            end
          end
        end
        PS_O: begin
          state <= PS_OL;
        end
        PS_OL: begin
          idx   <= od_rdata;
          state <= PS_D;
        end
        PS_D: begin
          if (!take_hit || can_push) begin
            if (take_hit) begin
              if (pend_valid) begin
                ovalid   <= 1'b1;
                o_group  <= pend_group;
                o_number <= pend_number;
                o_gdone  <= 1'b0;
                o_adone  <= 1'b0;
              end
              pend_valid  <= 1'b1;
              pend_group  <= group;
              pend_number <= NW'(idx) + NW'(1);
              last_end    <= rd_end;
              first       <= 1'b0;
              done        <= done + CW'(1);
            end
            k     <= AW'(k + AW'(1));
            state <= k_last ? PS_E : PS_O;
          end
        end
        PS_E: begin
          if (out_free) begin
            ovalid     <= 1'b1;
            o_group    <= pend_group;
            o_number   <= pend_number;
            o_gdone    <= 1'b1;
            o_adone    <= (done == n);
            pend_valid <= 1'b0;
            group      <= GW'(group + GW'(1));
            first      <= 1'b1;
            k          <= '0;
            if (done == n) begin
              count <= '0;
              state <= LOAD;
            end else begin
              state <= PS_O;
            end
          end
        end
        default: begin
          state <= LOAD;
        end
      endcase
    end
  end

  assign results.valid           = ovalid;
  assign results.group_index     = o_group;
  assign results.interval_number = o_number;
  assign results.group_done      = o_gdone;
  assign results.all_done        = o_adone;

  // A new set is only loaded once the previous run has flushed its held result.
  `GIP_ASSERT_IMPLY(a_load_no_pend, intervals.ready, !pend_valid, "held result while loading")
  // Every pass takes at least one interval, so a pass always closes a held result.
  `GIP_ASSERT_IMPLY(a_close_has_pend, state == PS_E, pend_valid, "pass closed with no result")
  // The run never takes more intervals than were loaded.
  `GIP_ASSERT_IMPLY(a_done_bound, state != LOAD, done <= n || state != PS_E,
                    "taken count above set size")

endmodule

`default_nettype wire
